/* design/sdsa_pkg.sv */
// sdsa_pkg: shared types, codes and defaults for the sparse-dense scatter-accumulate block
// no dependencies; compiled first
`default_nettype none

package sdsa_pkg;

  // default sizes of the stores
  localparam int MAX_ROWS_DEF     = 1024;
  localparam int MAX_FEATURES_DEF = 16;

  // feature columns reachable through the 4-bit feature fields
  localparam int FEAT_LIMIT = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd1;

  localparam int FEATURES_W = 5;
  localparam int ROWS_W     = 11;
  localparam logic [FEATURES_W-1:0] FEATURES_RST = 5'd16;
  localparam logic [ROWS_W-1:0]     ROWS_RST     = 11'd1024;

  // item opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ACCUM = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_READ
  } seq_state_t;

  // per-cycle command from the sequencer to the accumulator datapath
  typedef struct packed {
    logic rmw;     // read-modify-write of one accumulator element
    logic rd_out;  // read one element for the result queue
    logic clr;     // write zero
    logic zero;    // row out of range, report zero
    logic last;    // final feature of the item
  } acc_cmd_t;

  // one result beat
  typedef struct packed {
    logic [3:0]         feature;
    logic signed [31:0] sum;
    logic               last;
  } result_t;

  // saturating 32-bit signed add
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

/* design/sdsa_item_if.sv */
// sdsa_item_if: input item channel (valid/ready plus item fields)
// depends on nothing
`default_nettype none

interface sdsa_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               backward_mode;
  logic [9:0]         row_index;
  logic [9:0]         col_index;
  logic [3:0]         feature_index;
  logic signed [15:0] value;

  modport source (output valid, opcode, backward_mode, row_index, col_index,
                  feature_index, value, input ready);
  modport sink (input valid, opcode, backward_mode, row_index, col_index,
                feature_index, value, output ready);
endinterface

`default_nettype wire

/* design/sdsa_result_if.sv */
// sdsa_result_if: result channel (valid/ready plus result fields)
// depends on nothing
`default_nettype none

interface sdsa_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_feature;
  logic signed [31:0] out_sum;
  logic               last;

  modport source (output valid, out_feature, out_sum, last, input ready);
  modport sink (input valid, out_feature, out_sum, last, output ready);
endinterface

`default_nettype wire

/* design/sdsa_cfg_if.sv */
// sdsa_cfg_if: configuration write channel (valid/ready, register index, write data)
// depends on sdsa_pkg for field widths
`default_nettype none

interface sdsa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sdsa_pkg::CFG_IDX_W-1:0]   index;
  logic [sdsa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/sdsa_dense_mem.sv */
// sdsa_dense_mem: dense operand store, one write port and one registered read port
// depends on nothing outside itself
`default_nettype none

module sdsa_dense_mem #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_FEATURES = 16,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int AW = RW + FW
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic signed [15:0]   wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic signed [15:0]        q
);

  localparam int DEPTH = 2 ** AW;

  logic signed [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/sdsa_accum.sv */
// sdsa_accum: accumulator store with its multiply / saturating-add write-back pipeline
// depends on sdsa_pkg (acc_cmd_t, result_t, sat_add)
`default_nettype none

module sdsa_accum #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_FEATURES = 16,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int AW = RW + FW
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sdsa_pkg::acc_cmd_t  cmd,
  input  wire logic [3:0]          feat,
  input  wire logic [AW-1:0]       acc_addr,
  input  wire logic signed [15:0]  nz_value,
  input  wire logic signed [15:0]  dense_q,
  output logic                     push,
  output sdsa_pkg::result_t        push_data
);

  localparam int DEPTH = 2 ** AW;

  logic signed [31:0] acc_mem [DEPTH];
  logic signed [31:0] acc_q;

  // stage 1: read data back from both stores
  logic            s1_rmw;
  logic            s1_rd_out;
  logic            s1_zero;
  logic            s1_last;
  logic [3:0]      s1_feat;
  logic [AW-1:0]   s1_addr;

  // stage 2: product and old sum, write-back
  logic               s2_rmw;
  logic [AW-1:0]      s2_addr;
  logic signed [31:0] s2_acc;
  logic signed [31:0] s2_prod;

  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic signed [31:0] prod;

  // q8.8 times q8.8 is exact in q16.16
  assign prod = nz_value * dense_q;

  // one read port shared by read-modify-write and read-out
  assign rd_en = cmd.rmw || cmd.rd_out;

  // one write port: clear sweep or write-back, never both in a cycle
  always_comb begin
    wr_en   = cmd.clr || s2_rmw;
    wr_addr = cmd.clr ? acc_addr : s2_addr;
    wr_data = cmd.clr ? 32'sd0 : sdsa_pkg::sat_add(s2_acc, s2_prod);
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      acc_q <= acc_mem[acc_addr];
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_rmw    <= 1'b0;
      s1_rd_out <= 1'b0;
      s2_rmw    <= 1'b0;
    end else begin
      s1_rmw    <= cmd.rmw;
      s1_rd_out <= cmd.rd_out;
      s2_rmw    <= s1_rmw;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s1_zero <= cmd.zero;
    s1_last <= cmd.last;
    s1_feat <= feat;
    s1_addr <= acc_addr;
    s2_addr <= s1_addr;
    s2_acc  <= acc_q;
    s2_prod <= prod;
  end

  // read-out beat toward the result queue
  always_comb begin
    push              = s1_rd_out;
    push_data.feature = s1_feat;
    push_data.sum     = s1_zero ? 32'sd0 : acc_q;
    push_data.last    = s1_last;
  end

endmodule

`default_nettype wire

/* design/sdsa_outq.sv */
// sdsa_outq: two-entry result queue with a credit for the read-out sequencer
// depends on sdsa_pkg (result_t) and sdsa_result_if
`default_nettype none

module sdsa_outq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sdsa_pkg::result_t  push_data,
  output logic                    credit,
  sdsa_result_if.source           result
);

  sdsa_pkg::result_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  logic [2:0] occ;

  assign pop = result.valid && result.ready;

  // room for one more read issued now, counting the beat in flight
  assign occ    = 3'(count) + 3'(push) - 3'(pop);
  assign credit = occ < 3'd2;

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= occ[1:0];
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // head beat
  always_comb begin
    result.valid       = count != 2'd0;
    result.out_feature = slot[rd_ptr].feature;
    result.out_sum     = slot[rd_ptr].sum;
    result.last        = slot[rd_ptr].last;
  end

endmodule

`default_nettype wire

/* design/sdsa_seq.sv */
// sdsa_seq: item decode, configuration registers and the per-feature address sequencer
// depends on sdsa_pkg, sdsa_item_if and sdsa_cfg_if
`default_nettype none

module sdsa_seq #(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_FEATURES = 16,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int AW = RW + FW
) (
  input  wire logic                clk,
  input  wire logic                rst,
  sdsa_item_if.sink                item,
  sdsa_cfg_if.sink                 cfg,
  input  wire logic                credit,
  output sdsa_pkg::acc_cmd_t       cmd,
  output logic [3:0]               feat,
  output logic [AW-1:0]            acc_addr,
  output logic                     dense_we,
  output logic [AW-1:0]            dense_waddr,
  output logic signed [15:0]       dense_wdata,
  output logic                     dense_re,
  output logic [AW-1:0]            dense_raddr,
  output logic signed [15:0]       nz_value
);

  localparam int FEAT_CAP = (MAX_FEATURES < sdsa_pkg::FEAT_LIMIT) ?
                            MAX_FEATURES : sdsa_pkg::FEAT_LIMIT;
  localparam logic [AW:0] FULL_LIMIT = (AW+1)'(MAX_ROWS) << FW;

  sdsa_pkg::seq_state_t state;
  sdsa_pkg::seq_state_t state_next;

  logic [sdsa_pkg::FEATURES_W-1:0] features_in_use;
  logic [sdsa_pkg::ROWS_W-1:0]     rows_in_use;

  logic [3:0]         k;
  logic [4:0]         f_cnt;
  logic [RW-1:0]      src_a;
  logic [RW-1:0]      dst_a;
  logic               zero_r;
  logic signed [15:0] value_r;
  logic [AW:0]        sweep_addr;
  logic [AW:0]        sweep_limit;

  logic               accepted;
  logic               step;
  logic               last_k;
  logic [4:0]         f_now;
  logic [9:0]         src;
  logic [9:0]         dst;
  logic               src_ok;
  logic               dst_ok;
  logic               load_ok;
  logic [31:0]        rows_clamped;
  logic [AW:0]        clr_limit;

  assign accepted = item.valid && item.ready;
  assign last_k   = (5'(k) + 5'd1) == f_cnt;
  assign nz_value = value_r;

  // configuration registers, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      features_in_use <= sdsa_pkg::FEATURES_RST;
      rows_in_use     <= sdsa_pkg::ROWS_RST;
    end else if (cfg.valid) begin
      if (cfg.index == sdsa_pkg::REG_FEATURES) begin
        features_in_use <= cfg.data[sdsa_pkg::FEATURES_W-1:0];
      end else if (cfg.index == sdsa_pkg::REG_ROWS) begin
        rows_in_use <= cfg.data[sdsa_pkg::ROWS_W-1:0];
      end
    end
  end

  // effective feature count and clear length
  always_comb begin
    if (features_in_use == '0) begin
      f_now = 5'd1;
    end else if (32'(features_in_use) > 32'(FEAT_CAP)) begin
      f_now = 5'(FEAT_CAP);
    end else begin
      f_now = features_in_use;
    end
    rows_clamped = (32'(rows_in_use) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(rows_in_use);
    clr_limit    = (AW+1)'(rows_clamped) << FW;
  end

  // item decode; backward mode swaps source and target rows
  always_comb begin
    src     = item.backward_mode ? item.row_index : item.col_index;
    dst     = (item.opcode == sdsa_pkg::OP_ACCUM && item.backward_mode) ?
              item.col_index : item.row_index;
    src_ok  = 32'(src) < 32'(MAX_ROWS);
    dst_ok  = 32'(dst) < 32'(MAX_ROWS);
    load_ok = (32'(item.row_index) < 32'(MAX_ROWS)) &&
              (32'(item.feature_index) < 32'(MAX_FEATURES));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdsa_pkg::ST_SWEEP: begin
        if ((sweep_addr + (AW+1)'(1)) >= sweep_limit) begin
          state_next = sdsa_pkg::ST_IDLE;
        end
      end
      sdsa_pkg::ST_IDLE: begin
        if (accepted) begin
          case (item.opcode)
            sdsa_pkg::OP_ACCUM: begin
              if (src_ok && dst_ok) begin
                state_next = sdsa_pkg::ST_ACC;
              end
            end
            sdsa_pkg::OP_CLEAR: state_next = sdsa_pkg::ST_SWEEP;
            sdsa_pkg::OP_READ:  state_next = sdsa_pkg::ST_READ;
            default:            state_next = sdsa_pkg::ST_IDLE;
          endcase
        end
      end
      sdsa_pkg::ST_ACC: begin
        if (last_k) begin
          state_next = sdsa_pkg::ST_DRAIN;
        end
      end
      sdsa_pkg::ST_DRAIN: state_next = sdsa_pkg::ST_IDLE;
      sdsa_pkg::ST_READ: begin
        if (credit && last_k) begin
          state_next = sdsa_pkg::ST_IDLE;
        end
      end
      default: state_next = sdsa_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake, memory commands and addresses
  always_comb begin
    item.ready  = state == sdsa_pkg::ST_IDLE;
    cmd         = '0;
    cmd.last    = last_k;
    feat        = k;
    acc_addr    = {dst_a, FW'(k)};
    dense_re    = 1'b0;
    dense_raddr = {src_a, FW'(k)};
    step        = 1'b0;
    case (state)
      sdsa_pkg::ST_SWEEP: begin
        cmd.clr  = sweep_addr < sweep_limit;
        acc_addr = sweep_addr[AW-1:0];
      end
      sdsa_pkg::ST_ACC: begin
        cmd.rmw  = 1'b1;
        dense_re = 1'b1;
        step     = 1'b1;
      end
      sdsa_pkg::ST_READ: begin
        cmd.rd_out = credit;
        cmd.zero   = zero_r;
        step       = credit;
      end
      default: begin
        cmd.rmw = 1'b0;
      end
    endcase
    dense_we    = item.valid && (state == sdsa_pkg::ST_IDLE) &&
                  (item.opcode == sdsa_pkg::OP_LOAD) && load_ok;
    dense_waddr = {RW'(item.row_index), FW'(item.feature_index)};
    dense_wdata = item.value;
  end

  // state, feature counter and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sdsa_pkg::ST_SWEEP;
      k           <= 4'd0;
      sweep_addr  <= '0;
      sweep_limit <= FULL_LIMIT;
    end else begin
      state <= state_next;
      if (accepted) begin
        k           <= 4'd0;
        sweep_addr  <= '0;
        sweep_limit <= clr_limit;
      end else begin
        if (step) begin
          k <= k + 4'd1;
        end
        if (state == sdsa_pkg::ST_SWEEP) begin
          sweep_addr <= sweep_addr + (AW+1)'(1);
        end
      end
    end
  end

  // item payload held for the duration of the item
  always_ff @(posedge clk) begin
    if (accepted) begin
      f_cnt   <= f_now;
      src_a   <= RW'(src);
      dst_a   <= RW'(dst);
      zero_r  <= !(32'(item.row_index) < 32'(MAX_ROWS));
      value_r <= item.value;
    end
  end

endmodule

`default_nettype wire

/* design/sparse_dense_scatter_accumulate.sv */
// Sparse-times-dense scatter-accumulate (CSR SpMM, one nonzero per item). A dense
// element load is written in the cycle in which it is accepted. An accumulate has
// its accept cycle, then one element per cycle for each of the F effective features
// through the single read and write port of the accumulator memory, then a drain
// state that lets the multiply and saturating write-back pipeline finish before the
// next item is taken. A read-out issues one element per cycle while the two-entry
// result queue has room, and the next item is taken once the last element is issued.
// A clear sweeps min(rows_in_use, MAX_ROWS) * 2**FW entries, with FW the larger of 1
// and ceil(log2(MAX_FEATURES)), one per cycle after its accept cycle; after reset the
// same pass covers all MAX_ROWS rows (MAX_ROWS * 2**FW entries, 16384 by default)
// with item.ready low. Configuration writes are accepted in every cycle.
// depends on sdsa_pkg, the three channel interfaces and the sdsa_* submodules
`default_nettype none

module sparse_dense_scatter_accumulate #(
  parameter int MAX_ROWS     = sdsa_pkg::MAX_ROWS_DEF,
  parameter int MAX_FEATURES = sdsa_pkg::MAX_FEATURES_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int AW = RW + FW
) (
  input  wire logic     clk,
  input  wire logic     rst,
  sdsa_item_if.sink     item,
  sdsa_result_if.source result,
  sdsa_cfg_if.sink      cfg
);

  sdsa_pkg::acc_cmd_t  cmd;
  sdsa_pkg::result_t   push_data;
  logic [3:0]          feat;
  logic [AW-1:0]       acc_addr;
  logic                dense_we;
  logic [AW-1:0]       dense_waddr;
  logic signed [15:0]  dense_wdata;
  logic                dense_re;
  logic [AW-1:0]       dense_raddr;
  logic signed [15:0]  dense_q;
  logic signed [15:0]  nz_value;
  logic                credit;
  logic                push;

  // decode and sequencing
  sdsa_seq #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cfg         (cfg),
    .credit      (credit),
    .cmd         (cmd),
    .feat        (feat),
    .acc_addr    (acc_addr),
    .dense_we    (dense_we),
    .dense_waddr (dense_waddr),
    .dense_wdata (dense_wdata),
    .dense_re    (dense_re),
    .dense_raddr (dense_raddr),
    .nz_value    (nz_value)
  );

  // dense operand store
  sdsa_dense_mem #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dense (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .re    (dense_re),
    .raddr (dense_raddr),
    .q     (dense_q)
  );

  // accumulator store and write-back pipeline
  sdsa_accum #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .feat      (feat),
    .acc_addr  (acc_addr),
    .nz_value  (nz_value),
    .dense_q   (dense_q),
    .push      (push),
    .push_data (push_data)
  );

  // result queue
  sdsa_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .credit    (credit),
    .result    (result)
  );

endmodule

`default_nettype wire

/* design/sdsa_checker.sv */
// sdsa_checker: port-level assertions for sparse_dense_scatter_accumulate, bound to the top
// depends on sdsa_pkg (opcodes) and the top level's ports
`default_nettype none

module sdsa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic [1:0]  item_opcode,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [3:0]  res_feature,
  input wire logic [31:0] res_sum,
  input wire logic        res_last
);

  logic [3:0] exp_feat;
  logic [2:0] reads_open;
  logic       read_in;
  logic       row_done;

  assign read_in  = item_valid && item_ready && (item_opcode == sdsa_pkg::OP_READ);
  assign row_done = res_valid && res_ready && res_last;

  // expected feature of the next result beat, and read items not yet fully returned
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_feat   <= 4'd0;
      reads_open <= 3'd0;
    end else begin
      if (res_valid && res_ready) begin
        exp_feat <= res_last ? 4'd0 : exp_feat + 4'd1;
      end
      reads_open <= reads_open + 3'(read_in) - 3'(row_done);
    end
  end

  // clearing pass keeps items out right after reset
  a_sweep_after_reset: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("item accepted during the post-reset clearing pass");

  // features of a row come out in order from zero
  a_feature_order: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_feature == exp_feat)
    else $error("result beat out of feature order");

  // no result beat without a read item behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> reads_open != 3'd0)
    else $error("result beat with no read item open");

  // stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_sum) && $stable(res_feature))
    else $error("stalled result beat changed");

endmodule

bind sparse_dense_scatter_accumulate sdsa_checker u_sdsa_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .item_opcode (item.opcode),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_feature (result.out_feature),
  .res_sum     (result.out_sum),
  .res_last    (result.last)
);

`default_nettype wire
